FILE: src/fdf_pkg.sv
// Shared types and codes for the flooding duplicate filter.
// No dependencies; used by fdf_cache and flood_duplicate_filter.
package fdf_pkg;

  localparam int ADDR_W  = 16;
  localparam int SEQ_W   = 16;
  localparam int HOPS_W  = 8;
  localparam int KEY_W   = ADDR_W + SEQ_W;
  localparam int COUNT_W = 32;
  localparam int ROLE_W  = 2;
  localparam int VERD_W  = 2;

  localparam logic [ROLE_W-1:0] ROLE_GATEWAY = 2'd0;
  localparam logic [ROLE_W-1:0] ROLE_RELAY   = 2'd1;
  localparam logic [ROLE_W-1:0] ROLE_SENSOR  = 2'd2;
  localparam logic [ROLE_W-1:0] ROLE_RESET   = ROLE_RELAY;

  localparam logic [VERD_W-1:0] VERDICT_DUPLICATE = 2'd0;
  localparam logic [VERD_W-1:0] VERDICT_CONSUMED  = 2'd1;
  localparam logic [VERD_W-1:0] VERDICT_FORWARDED = 2'd2;
  localparam logic [VERD_W-1:0] VERDICT_EXHAUSTED = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

endpackage

FILE: src/fdf_cache.sv
// Ring cache storage for the duplicate filter: one write port, one read port
// with registered read data. Depends on fdf_pkg for the key width.
module fdf_cache #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic [fdf_pkg::KEY_W-1:0] wr_data,
  input  logic [AW-1:0]            rd_addr,
  output logic [fdf_pkg::KEY_W-1:0] rd_data
);

  logic [fdf_pkg::KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: src/flood_duplicate_filter.sv
// Each accepted header is compared against the cache by a walk over every entry
// through its single read port, one entry per cycle; the input stays stalled until the
// result word is loaded, so no new header is taken before the last one is through.
// Reset (rst, synchronous): clears counters, write pointer, fill count and
// handshake state and sets the role register to relay; the cache needs no
// clearing pass, since entries at or above the fill count never match.
module flood_duplicate_filter #(
  parameter int CACHE_ENTRIES = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_write,
  input  logic [fdf_pkg::ROLE_W-1:0]  cfg_data,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [fdf_pkg::ADDR_W-1:0]  source_address,
  input  logic [fdf_pkg::SEQ_W-1:0]   sequence_number,
  input  logic [fdf_pkg::HOPS_W-1:0]  hops_left,
  // output channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [fdf_pkg::VERD_W-1:0]  verdict,
  output logic                        rebroadcast,
  output logic [fdf_pkg::HOPS_W-1:0]  new_hops_left,
  output logic [fdf_pkg::COUNT_W-1:0] duplicate_count,
  output logic [fdf_pkg::COUNT_W-1:0] received_count,
  output logic [fdf_pkg::COUNT_W-1:0] forwarded_count
);

  // Address width of the cache and width of the fill count (holds DEPTH).
  localparam int AW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int FW = $clog2(CACHE_ENTRIES + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(CACHE_ENTRIES - 1);
  localparam logic [FW-1:0] FULL     = FW'(CACHE_ENTRIES);

  fdf_pkg::state_t state, state_next;

  logic [fdf_pkg::ROLE_W-1:0]  role;
  logic [fdf_pkg::ADDR_W-1:0]  src;
  logic [fdf_pkg::SEQ_W-1:0]   seq;
  logic [fdf_pkg::HOPS_W-1:0]  hops;
  logic [AW-1:0]               idx;
  logic [AW-1:0]               write_pointer;
  logic [FW-1:0]               fill;
  logic                        rd_live;
  logic                        hit;
  logic [fdf_pkg::KEY_W-1:0]   rd_data;
  logic [fdf_pkg::KEY_W-1:0]   key;
  logic                        in_take;
  logic                        out_free;
  logic                        finish;
  logic                        store;

  logic [fdf_pkg::COUNT_W-1:0] duplicates_seen;
  logic [fdf_pkg::COUNT_W-1:0] packets_accepted;
  logic [fdf_pkg::COUNT_W-1:0] packets_relayed;

  assign key      = {src, seq};
  assign in_stall = (state != fdf_pkg::ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  // The result slot is free when empty or when its word leaves this cycle.
  assign out_free = !out_valid || !out_stall;
  assign finish   = (state == fdf_pkg::ST_DONE) && out_free;
  assign store    = finish && !hit;

  // Counters stay put while a result waits, so they drive the count
  // fields directly.
  assign duplicate_count = duplicates_seen;
  assign received_count  = packets_accepted;
  assign forwarded_count = packets_relayed;

  fdf_cache #(
    .DEPTH (CACHE_ENTRIES),
    .AW    (AW)
  ) u_cache (
    .clk     (clk),
    .wr_en   (store),
    .wr_addr (write_pointer),
    .wr_data (key),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  // Sequencer: accept, walk every entry, compare the last read, decide.
  always_comb begin
    state_next = state;
    case (state)
      fdf_pkg::ST_IDLE: begin
        if (in_take) state_next = fdf_pkg::ST_SCAN;
      end
      fdf_pkg::ST_SCAN: begin
        if (idx == LAST_IDX) state_next = fdf_pkg::ST_DRAIN;
      end
      fdf_pkg::ST_DRAIN: begin
        state_next = fdf_pkg::ST_DONE;
      end
      fdf_pkg::ST_DONE: begin
        if (out_free) state_next = fdf_pkg::ST_IDLE;
      end
      default: begin
        state_next = fdf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fdf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration: to be written only while idle; the user is bound to this, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      role <= fdf_pkg::ROLE_RESET;
    end else if (cfg_write) begin
      role <= cfg_data;
    end
  end

  // Capture the header and restart the walk on accept.
  always_ff @(posedge clk) begin
    if (in_take) begin
      src  <= source_address;
      seq  <= sequence_number;
      hops <= hops_left;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (in_take) begin
      idx <= '0;
    end else if (state == fdf_pkg::ST_SCAN && idx != LAST_IDX) begin
      idx <= idx + AW'(1);
    end
  end

  // Shared compare unit: one entry per cycle, each compared in the cycle after
  // its read address. An entry counts only below the fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_live <= 1'b0;
      hit     <= 1'b0;
    end else begin
      rd_live <= (state == fdf_pkg::ST_SCAN) && (FW'(idx) < fill);
      if (in_take) begin
        hit <= 1'b0;
      end else if (rd_live && rd_data == key) begin
        hit <= 1'b1;
      end
    end
  end

  // Ring write pointer and fill count; advance only when a new pair is stored.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      fill          <= '0;
    end else if (store) begin
      if (write_pointer == LAST_IDX) begin
        write_pointer <= '0;
      end else begin
        write_pointer <= write_pointer + AW'(1);
      end
      if (fill != FULL) begin
        fill <= fill + FW'(1);
      end
    end
  end

  // Decide the verdict and bump the counters when the result is loaded.
  always_ff @(posedge clk) begin
    if (rst) begin
      duplicates_seen  <= '0;
      packets_accepted <= '0;
      packets_relayed  <= '0;
    end else if (finish) begin
      if (hit) begin
        duplicates_seen <= duplicates_seen + 32'd1;
      end else begin
        packets_accepted <= packets_accepted + 32'd1;
        if (role == fdf_pkg::ROLE_RELAY && hops != '0) begin
          packets_relayed <= packets_relayed + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      new_hops_left <= hops;
      rebroadcast   <= 1'b0;
      if (hit) begin
        verdict <= fdf_pkg::VERDICT_DUPLICATE;
      end else if (role == fdf_pkg::ROLE_RELAY) begin
        if (hops != '0) begin
          verdict       <= fdf_pkg::VERDICT_FORWARDED;
          rebroadcast   <= 1'b1;
          new_hops_left <= hops - 8'd1;
        end else begin
          verdict <= fdf_pkg::VERDICT_EXHAUSTED;
        end
      end else begin
        verdict <= fdf_pkg::VERDICT_CONSUMED;
      end
    end
  end

  // Result word: hold until taken, load when the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: test/fdf_checker.sv
// Checker for flood_duplicate_filter: watches the config port and both channels.
// It predicts each result word and compares it. Depends on fdf_pkg.
module fdf_checker #(
  parameter int CACHE_ENTRIES = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [fdf_pkg::ROLE_W-1:0]  cfg_data,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [fdf_pkg::ADDR_W-1:0]  source_address,
  input  logic [fdf_pkg::SEQ_W-1:0]   sequence_number,
  input  logic [fdf_pkg::HOPS_W-1:0]  hops_left,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [fdf_pkg::VERD_W-1:0]  verdict,
  input  logic                        rebroadcast,
  input  logic [fdf_pkg::HOPS_W-1:0]  new_hops_left,
  input  logic [fdf_pkg::COUNT_W-1:0] duplicate_count,
  input  logic [fdf_pkg::COUNT_W-1:0] received_count,
  input  logic [fdf_pkg::COUNT_W-1:0] forwarded_count,
  output int                          mismatches,
  output int                          pending
);

  localparam int ADDR_W  = fdf_pkg::ADDR_W;
  localparam int SEQ_W   = fdf_pkg::SEQ_W;
  localparam int HOPS_W  = fdf_pkg::HOPS_W;
  localparam int COUNT_W = fdf_pkg::COUNT_W;
  localparam int ROLE_W  = fdf_pkg::ROLE_W;
  localparam int VERD_W  = fdf_pkg::VERD_W;

  typedef struct packed {
    logic [VERD_W-1:0]  verdict;
    logic               rebroadcast;
    logic [HOPS_W-1:0]  new_hops;
    logic [COUNT_W-1:0] dup_count;
    logic [COUNT_W-1:0] rcv_count;
    logic [COUNT_W-1:0] fwd_count;
  } filter_word_t;

  logic [ADDR_W-1:0]  seen_source   [CACHE_ENTRIES];
  logic [SEQ_W-1:0]   seen_sequence [CACHE_ENTRIES];
  logic               seen_valid    [CACHE_ENTRIES];
  int unsigned        store_ptr;
  logic [COUNT_W-1:0] dups_seen;
  logic [COUNT_W-1:0] pkts_accepted;
  logic [COUNT_W-1:0] pkts_relayed;
  logic [ROLE_W-1:0]  role;
  filter_word_t       expected_words [$];
  filter_word_t       got_word;
  filter_word_t       want_word;
  int                 fail_count = 0;

  // Search the ring, store on a miss, and apply the role's forwarding rule.
  function automatic filter_word_t filter_header(input logic [ADDR_W-1:0] src,
                                                 input logic [SEQ_W-1:0]  seq,
                                                 input logic [HOPS_W-1:0] hops);
    filter_word_t w;
    bit           hit;
    hit           = 1'b0;
    w.rebroadcast = 1'b0;
    w.new_hops    = hops;
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      if (seen_valid[i] && seen_source[i] == src && seen_sequence[i] == seq) hit = 1'b1;
    end
    if (hit) begin
      dups_seen++;
      w.verdict = fdf_pkg::VERDICT_DUPLICATE;
    end else begin
      seen_source[store_ptr]   = src;
      seen_sequence[store_ptr] = seq;
      seen_valid[store_ptr]    = 1'b1;
      store_ptr                = (store_ptr + 1) % CACHE_ENTRIES;
      pkts_accepted++;
      if (role == fdf_pkg::ROLE_RELAY) begin
        if (hops != '0) begin
          w.new_hops    = hops - HOPS_W'(1);
          w.rebroadcast = 1'b1;
          pkts_relayed++;
          w.verdict     = fdf_pkg::VERDICT_FORWARDED;
        end else begin
          w.verdict = fdf_pkg::VERDICT_EXHAUSTED;
        end
      end else begin
        w.verdict = fdf_pkg::VERDICT_CONSUMED;
      end
    end
    w.dup_count = dups_seen;
    w.rcv_count = pkts_accepted;
    w.fwd_count = pkts_relayed;
    return w;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
        seen_source[i]   = '0;
        seen_sequence[i] = '0;
        seen_valid[i]    = 1'b0;
      end
      store_ptr     = 0;
      dups_seen     = '0;
      pkts_accepted = '0;
      pkts_relayed  = '0;
      role          = fdf_pkg::ROLE_RESET;
      expected_words.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got_word.verdict     = verdict;
        got_word.rebroadcast = rebroadcast;
        got_word.new_hops    = new_hops_left;
        got_word.dup_count   = duplicate_count;
        got_word.rcv_count   = received_count;
        got_word.fwd_count   = forwarded_count;
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("fdf_checker: result word with no packet outstanding, verdict %0d",
                     got_word.verdict);
        end else begin
          want_word = expected_words.pop_front();
          if (got_word !== want_word) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display({"fdf_checker: mismatch exp verdict %0d rebc %0d hops %0d",
                        " dup %0d rcv %0d fwd %0d"},
                       want_word.verdict, want_word.rebroadcast, want_word.new_hops,
                       want_word.dup_count, want_word.rcv_count, want_word.fwd_count);
              $display({"fdf_checker:          act verdict %0d rebc %0d hops %0d",
                        " dup %0d rcv %0d fwd %0d"},
                       got_word.verdict, got_word.rebroadcast, got_word.new_hops,
                       got_word.dup_count, got_word.rcv_count, got_word.fwd_count);
            end
          end
        end
      end
      if (in_valid && !in_stall)
        expected_words.push_back(filter_header(source_address, sequence_number, hops_left));
      if (cfg_write) role = cfg_data;
    end
    mismatches <= fail_count;
    pending    <= expected_words.size();
  end

endmodule

FILE: test/tb_flood_duplicate_filter.sv
// Testbench top for flood_duplicate_filter: clock, reset, config writes and headers.
// Depends on fdf_pkg, flood_duplicate_filter and fdf_checker.
module tb_flood_duplicate_filter;

  localparam int ADDR_W        = fdf_pkg::ADDR_W;
  localparam int SEQ_W         = fdf_pkg::SEQ_W;
  localparam int HOPS_W        = fdf_pkg::HOPS_W;
  localparam int KEY_W         = fdf_pkg::KEY_W;
  localparam int COUNT_W       = fdf_pkg::COUNT_W;
  localparam int ROLE_W        = fdf_pkg::ROLE_W;
  localparam int VERD_W        = fdf_pkg::VERD_W;
  localparam int CACHE_ENTRIES = 32;
  localparam int LATENCY       = CACHE_ENTRIES + 2;
  localparam int RANDOM_ITEMS  = 1150;
  localparam int PHASES        = 6;
  localparam int CYCLE_LIMIT   = 400000;
  // Role code with no meaning of its own; the block treats it as a consumer.
  localparam logic [ROLE_W-1:0] ROLE_UNUSED = 2'd3;

  logic               clk             = 1'b0;
  logic               rst             = 1'b1;
  logic               cfg_write       = 1'b0;
  logic [ROLE_W-1:0]  cfg_data        = fdf_pkg::ROLE_RESET;
  logic               in_valid        = 1'b0;
  logic [ADDR_W-1:0]  source_address  = '0;
  logic [SEQ_W-1:0]   sequence_number = '0;
  logic [HOPS_W-1:0]  hops_left       = '0;
  logic               out_stall       = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [VERD_W-1:0]  verdict;
  logic               rebroadcast;
  logic [HOPS_W-1:0]  new_hops_left;
  logic [COUNT_W-1:0] duplicate_count;
  logic [COUNT_W-1:0] received_count;
  logic [COUNT_W-1:0] forwarded_count;

  int                 mismatches;
  int                 pending;
  int                 cycle_count;
  // When set, neither side idles: headers go back to back, results never stall.
  bit                 quiet = 1'b0;
  // Recent {source, sequence} pairs, used to aim repeats at the cache.
  logic [KEY_W-1:0]   sent_pairs [$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  flood_duplicate_filter #(
    .CACHE_ENTRIES(CACHE_ENTRIES)
  ) dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .source_address  (source_address),
    .sequence_number (sequence_number),
    .hops_left       (hops_left),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .verdict         (verdict),
    .rebroadcast     (rebroadcast),
    .new_hops_left   (new_hops_left),
    .duplicate_count (duplicate_count),
    .received_count  (received_count),
    .forwarded_count (forwarded_count)
  );

  fdf_checker #(
    .CACHE_ENTRIES(CACHE_ENTRIES)
  ) filter_monitor (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .source_address  (source_address),
    .sequence_number (sequence_number),
    .hops_left       (hops_left),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .verdict         (verdict),
    .rebroadcast     (rebroadcast),
    .new_hops_left   (new_hops_left),
    .duplicate_count (duplicate_count),
    .received_count  (received_count),
    .forwarded_count (forwarded_count),
    .mismatches      (mismatches),
    .pending         (pending)
  );

  // Stall the result side at random, with a 16 percent chance, except in quiet stretches.
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < 16);
  end

  // Present one header word and hold it until the block takes it.
  task automatic send_header(input logic [ADDR_W-1:0] src,
                             input logic [SEQ_W-1:0]  seq,
                             input logic [HOPS_W-1:0] hops);
    // Idle the sender now and then; drop valid while idle.
    if (!quiet) begin
      while ($urandom_range(0, 99) < 16) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid        <= 1'b1;
    source_address  <= src;
    sequence_number <= seq;
    hops_left       <= hops;
    sent_pairs.push_back({src, seq});
    if (sent_pairs.size() > 64) void'(sent_pairs.pop_front());
    // Hold the word while stalled; the payload stays put.
    do @(posedge clk); while (in_stall);
  endtask

  // Write the role register, only once the block has gone idle.
  task automatic set_role(input logic [ROLE_W-1:0] role);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // Give the walk time to finish even after the last word has left.
    repeat (LATENCY + 2) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= role;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Pick a header that mostly exercises the cache: repeats of recent pairs hit,
  // repeats from about one ring ago land near the eviction boundary, a tiny pool
  // gives partial matches, and most of the rest are fresh full-range pairs.
  task automatic send_random_header();
    logic [ADDR_W-1:0] src;
    logic [SEQ_W-1:0]  seq;
    logic [HOPS_W-1:0] hops;
    int                pick;
    int                back;
    pick = $urandom_range(0, 99);
    if (pick < 30 && sent_pairs.size() > 0) begin
      back = $urandom_range(1, (sent_pairs.size() < 20) ? sent_pairs.size() : 20);
      {src, seq} = sent_pairs[sent_pairs.size() - back];
    end else if (pick < 42 && sent_pairs.size() > 40) begin
      back = $urandom_range(28, 40);
      {src, seq} = sent_pairs[sent_pairs.size() - back];
    end else if (pick < 57) begin
      src = ADDR_W'($urandom_range(0, 3));
      seq = SEQ_W'($urandom_range(0, 7));
    end else if (pick < 62) begin
      src = $urandom_range(0, 1) ? '1 : '0;
      seq = $urandom_range(0, 1) ? '1 : '0;
    end else begin
      src = ADDR_W'($urandom());
      seq = SEQ_W'($urandom());
    end
    pick = $urandom_range(0, 99);
    if (pick < 30)      hops = HOPS_W'($urandom_range(0, 2));
    else if (pick < 38) hops = '1;
    else                hops = HOPS_W'($urandom_range(0, 255));
    send_header(src, seq, hops);
  endtask

  // Watchdog: end the run if the traffic never drains.
  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("tb_flood_duplicate_filter NOT OK");
    $finish;
  end

  initial begin
    logic [ROLE_W-1:0] phase_role;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset role (relay). A zero pair must not match the empty cache.
    send_header(16'h0000, 16'h0000, 8'd0);    // new, relay with no hops left
    send_header(16'h0000, 16'h0000, 8'd5);    // duplicate, hops pass unchanged
    send_header(16'hFFFF, 16'hFFFF, 8'd255);  // forwarded at top hop count
    send_header(16'hFFFF, 16'h0000, 8'd1);    // same source, new sequence
    send_header(16'h0000, 16'hFFFF, 8'd1);    // same sequence, new source
    send_header(16'hFFFF, 16'hFFFF, 8'd0);    // duplicate of the top pair
    send_header(16'h5555, 16'hAAAA, 8'd128);
    send_header(16'hAAAA, 16'h5555, 8'd2);

    // Gateway and sensor terminate; duplicates still drop.
    set_role(fdf_pkg::ROLE_GATEWAY);
    send_header(16'h1234, 16'h0001, 8'd3);
    send_header(16'h1234, 16'h0001, 8'd3);
    send_header(16'h0000, 16'h0000, 8'd9);    // still cached from the relay phase
    set_role(fdf_pkg::ROLE_SENSOR);
    send_header(16'h1234, 16'h0002, 8'd7);
    send_header(16'h1234, 16'h0002, 8'd7);
    send_header(16'h4321, 16'hFFFF, 8'd255);

    // Unused role code consumes like a sensor.
    set_role(ROLE_UNUSED);
    send_header(16'hAAAA, 16'hAAAA, 8'd9);
    send_header(16'hAAAA, 16'hAAAA, 8'd0);
    send_header(16'h5555, 16'h5555, 8'd1);

    // Random phases, one role each; phase 4 runs with no idling on either side.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       phase_role = fdf_pkg::ROLE_RELAY;
        1:       phase_role = fdf_pkg::ROLE_GATEWAY;
        2:       phase_role = fdf_pkg::ROLE_SENSOR;
        3:       phase_role = ROLE_UNUSED;
        4:       phase_role = fdf_pkg::ROLE_RELAY;
        default: phase_role = ROLE_W'($urandom_range(0, 3));
      endcase
      set_role(phase_role);
      quiet <= (phase == 4);
      repeat (RANDOM_ITEMS / PHASES) send_random_header();
    end

    // Drain: drop valid, wait for every word, then a walk's worth of cycles more.
    quiet    <= 1'b0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_flood_duplicate_filter OK");
    end else begin
      $display("tb_flood_duplicate_filter NOT OK");
    end
    $finish;
  end

endmodule
